// ===== rtl/core/csq_pkg.sv =====
// Shared types and codes for the counting semaphore wait queue unit.
`default_nettype none

package csq_pkg;

  localparam int CountW = 16;
  localparam int TaskW  = 8;

  // opcodes
  localparam logic OP_TAKE = 1'b0;
  localparam logic OP_GIVE = 1'b1;

  // result status codes
  localparam logic [2:0] ST_GRANTED = 3'd0;
  localparam logic [2:0] ST_REFUSED = 3'd1;
  localparam logic [2:0] ST_QUEUED  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_WOKEN   = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  // configuration register indexes
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_LIMIT   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_INITIAL = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [CountW-1:0] amount;
    logic [TaskW-1:0]  task_id;
    logic              may_wait;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [TaskW-1:0]  who;
    logic [CountW-1:0] units;
    logic              last;
  } out_beat_t;

  // one wait queue entry
  typedef struct packed {
    logic [TaskW-1:0]  task_id;
    logic [CountW-1:0] need;
  } entry_t;

  // compare and subtract result
  typedef struct packed {
    logic              ge;
    logic [CountW-1:0] diff;
  } cmp_t;

endpackage

`default_nettype wire

// ===== rtl/core/csq_cmp_sub.sv =====
// Shared compare and subtract unit: checks a >= b and forms a - b.
`default_nettype none

module csq_cmp_sub (
  input  wire logic [csq_pkg::CountW-1:0] a,
  input  wire logic [csq_pkg::CountW-1:0] b,
  output csq_pkg::cmp_t                   res
);

  // borrow out of the subtract decides the compare
  logic [csq_pkg::CountW:0] diff_ext;

  assign diff_ext = {1'b0, a} - {1'b0, b};
  assign res.ge   = ~diff_ext[csq_pkg::CountW];
  assign res.diff = diff_ext[csq_pkg::CountW-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/csq_queue_mem.sv =====
// Wait queue storage: one write port, one registered read port.
`default_nettype none

module csq_queue_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire csq_pkg::entry_t wr_entry,
  input  wire logic [AW-1:0]   rd_addr,
  output csq_pkg::entry_t      rd_entry
);

  csq_pkg::entry_t mem [DEPTH];
  csq_pkg::entry_t rd_entry_r;

  // write entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // register read data
  always_ff @(posedge clk) begin
    rd_entry_r <= mem[rd_addr];
  end

  assign rd_entry = rd_entry_r;

endmodule

`default_nettype wire

// ===== rtl/core/counting_semaphore_wait_queue_unit.sv =====
// Top level of the counting semaphore with a bounded wait queue.
//
// A take (opcode 0) is decided in the cycle it is accepted; its single result
// appears on out_data with out_valid in the next cycle and busy stays low, so
// takes may be issued every cycle. A give (opcode 1) raises busy, which stays
// high through the scan of its N queued waiters and the done step: the queue
// memory is read one entry per cycle and each entry passes once through the
// shared compare and subtract unit, which wakes it or packs it down. Woken
// results leave at most one per cycle, then the give done result with last
// set. Results are strobed by out_valid for exactly one cycle and cannot be
// stalled. Configuration writes on cfg_we take effect at once; write them
// only while busy is low and no result is pending.
`default_nettype none

module counting_semaphore_wait_queue_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire csq_pkg::in_beat_t             in_data,
  output logic                               out_valid,
  output csq_pkg::out_beat_t                 out_data,
  input  wire logic                          cfg_we,
  input  wire logic [csq_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [csq_pkg::CountW-1:0]    cfg_data
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int W  = csq_pkg::CountW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [W-1:0]        count_r, count_nxt;
  logic [W-1:0]        limit_r, limit_nxt;
  logic [W-1:0]        added_r, added_nxt;
  logic [CW-1:0]       total_r, total_nxt;
  logic [CW-1:0]       keep_r, keep_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  csq_pkg::out_beat_t  out_data_r, out_data_nxt;

  logic                accept;
  logic [W-1:0]        alu_b;
  csq_pkg::cmp_t       alu_res;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  csq_pkg::entry_t     wr_entry;
  logic [AW-1:0]       rd_addr;
  csq_pkg::entry_t     rd_entry;
  logic [CW-1:0]       idx_inc;
  logic [CW-1:0]       keep_inc;
  logic                q_full;
  logic                wake;
  logic [W:0]          give_sum;
  logic                give_over;
  logic [W-1:0]        give_added;
  logic [W-1:0]        give_count;

  assign accept   = start && (state_r == S_IDLE);
  assign idx_inc  = idx_r + CW'(1);
  assign keep_inc = keep_r + CW'(1);
  assign q_full   = (total_r == CW'(QUEUE_DEPTH));

  // shared compare and subtract: request on intake, waiter need during scan
  assign alu_b = (state_r == S_SCAN) ? rd_entry.need : in_data.amount;

  csq_cmp_sub u_cmp_sub (
    .a   (count_r),
    .b   (alu_b),
    .res (alu_res)
  );

  csq_queue_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_queue_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  // give: add and clip at the limit
  assign give_sum   = {1'b0, count_r} + {1'b0, in_data.amount};
  assign give_over  = give_sum > {1'b0, limit_r};
  assign give_count = give_over ? limit_r : give_sum[W-1:0];
  assign give_added = !give_over         ? in_data.amount :
                      (limit_r > count_r) ? (limit_r - count_r) : '0;

  // wake a waiter whose need fits a nonzero count
  assign wake = (count_r != '0) && alu_res.ge;

  // read ahead: entry 0 on give intake, next entry while scanning
  assign rd_addr = (state_r == S_SCAN) ? idx_inc[AW-1:0] : '0;

  // sequencer and queue writes
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    limit_nxt     = limit_r;
    added_nxt     = added_r;
    total_nxt     = total_r;
    keep_nxt      = keep_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = keep_r[AW-1:0];
    wr_entry      = rd_entry;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.opcode == csq_pkg::OP_TAKE) begin
            out_valid_nxt        = 1'b1;
            out_data_nxt.who     = in_data.task_id;
            out_data_nxt.last    = 1'b1;
            out_data_nxt.units   = '0;
            if (alu_res.ge) begin
              count_nxt           = alu_res.diff;
              out_data_nxt.status = csq_pkg::ST_GRANTED;
              out_data_nxt.units  = in_data.amount;
            end else if (!in_data.may_wait) begin
              out_data_nxt.status = csq_pkg::ST_REFUSED;
            end else if (q_full) begin
              out_data_nxt.status = csq_pkg::ST_FULL;
            end else begin
              wr_en               = 1'b1;
              wr_addr             = total_r[AW-1:0];
              wr_entry.task_id    = in_data.task_id;
              wr_entry.need       = in_data.amount;
              total_nxt           = total_r + CW'(1);
              out_data_nxt.status = csq_pkg::ST_QUEUED;
            end
          end else begin
            count_nxt = give_count;
            added_nxt = give_added;
            idx_nxt   = '0;
            keep_nxt  = '0;
            state_nxt = (total_r == '0) ? S_DONE : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (wake) begin
          count_nxt           = alu_res.diff;
          out_valid_nxt       = 1'b1;
          out_data_nxt.status = csq_pkg::ST_WOKEN;
          out_data_nxt.who    = rd_entry.task_id;
          out_data_nxt.units  = rd_entry.need;
          out_data_nxt.last   = 1'b0;
        end else begin
          wr_en    = 1'b1;
          keep_nxt = keep_inc;
        end
        idx_nxt = idx_inc;
        if (idx_inc == total_r) begin
          total_nxt = wake ? keep_r : keep_inc;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        out_valid_nxt       = 1'b1;
        out_data_nxt.status = csq_pkg::ST_DONE;
        out_data_nxt.who    = '0;
        out_data_nxt.units  = added_r;
        out_data_nxt.last   = 1'b1;
        state_nxt           = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        csq_pkg::CFG_LIMIT:   limit_nxt = cfg_data;
        csq_pkg::CFG_INITIAL: count_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      limit_r     <= '1;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      limit_r     <= limit_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    added_r    <= added_nxt;
    keep_r     <= keep_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
